### sv/spdev_pkg.sv
// ----------------------------------------------------------------------------
// spdev_pkg
// Shared widths, codes and reset values for the spectral region deviation
// check.
// ----------------------------------------------------------------------------
package spdev_pkg;

  localparam int BAND_W      = 12;
  localparam int DEV_W       = 13;
  localparam int TOL_W       = 11;
  localparam int REGION_W    = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int NUM_OFFSETS = 6;

  localparam int BANDS_PER_REGION_DEF = 5;
  localparam int REGIONS_DEF          = 6;

  localparam logic signed [BAND_W-1:0] VALID_FLOOR  = -12'sd1280;
  localparam logic signed [BAND_W-1:0] SIGNAL_FLOOR = -12'sd960;

  localparam logic [REGION_W-1:0] NO_REGION = 3'd6;

  localparam logic [1:0] STATUS_NO_SIGNAL = 2'd0;
  localparam logic [1:0] STATUS_ON        = 2'd1;
  localparam logic [1:0] STATUS_NEAR      = 2'd2;
  localparam logic [1:0] STATUS_OFF       = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TOL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_C  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_D  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_E  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_F  = 3'd7;

  localparam logic [TOL_W-1:0] TOL_RESET  = 11'd48;
  localparam logic [TOL_W-1:0] NEAR_RESET = 11'd96;

  localparam logic signed [DEV_W-1:0] DEV_MAX = 13'sd4095;
  localparam logic signed [DEV_W-1:0] DEV_MIN = -13'sd4096;

endpackage

### sv/spectral_region_deviation_check.sv
// ----------------------------------------------------------------------------
// spectral_region_deviation_check
// Averages band energies per region, tracks the region farthest from its
// expected level and reports a verdict at the end of each track.
// ----------------------------------------------------------------------------
// A band that does not close a region is taken in while the block stays idle,
// so it is ready for the next band without a stall. A band that closes a region
// passes through these steps: intake, one step per dividend bit in the shared
// restoring divider that forms the region average, one to form the
// deviation and one to compare it against the worst so far. The last band of
// a track adds a step to move the verdict into the output register; a
// pending verdict that is not yet taken holds that step.
module spectral_region_deviation_check
  import spdev_pkg::*;
#(
  parameter int BANDS_PER_REGION = BANDS_PER_REGION_DEF,
  parameter int REGIONS          = REGIONS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         band_valid,
  output logic                         band_stall,
  input  logic signed [BAND_W-1:0]     band_energy,
  input  logic signed [BAND_W-1:0]     peak_level,
  input  logic                         first_band,
  output logic                         verdict_valid,
  input  logic                         verdict_stall,
  output logic [1:0]                   status,
  output logic [REGION_W-1:0]          worst_region,
  output logic signed [DEV_W-1:0]      worst_deviation,
  output logic                         is_excess,
  output logic signed [BAND_W-1:0]     worst_energy,
  output logic signed [DEV_W-1:0]      worst_expected,
  output logic signed [BAND_W-1:0]     peak_out,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int CNT_W  = $clog2(BANDS_PER_REGION + 1);
  localparam int SUM_W  = BAND_W + CNT_W;
  localparam int DVD_W  = SUM_W - 1;
  localparam int STEP_W = $clog2(DVD_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_DEV  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state;

  logic [TOL_W-1:0]             tolerance;
  logic [TOL_W-1:0]             near_tolerance;
  logic signed [BAND_W-1:0]     offset [NUM_OFFSETS];

  logic [CNT_W-1:0]             bir;
  logic [REGION_W-1:0]          region;
  logic signed [SUM_W-1:0]      region_sum;
  logic [CNT_W-1:0]             valid_count;
  logic signed [BAND_W-1:0]     held_peak;
  logic [DEV_W-1:0]             worst_magnitude;
  logic [REGION_W-1:0]          worst_index;
  logic signed [DEV_W-1:0]      worst_signed;
  logic signed [BAND_W-1:0]     worst_avg;
  logic signed [DEV_W-1:0]      worst_target;

  logic [DVD_W-1:0]             dq;
  logic [CNT_W-1:0]             rem;
  logic [CNT_W-1:0]             div_cnt;
  logic                         div_neg;
  logic [STEP_W-1:0]            step;

  logic signed [DEV_W-1:0]      dev_sat;
  logic [DEV_W-1:0]             dev_mag;
  logic signed [BAND_W-1:0]     dev_avg;
  logic signed [DEV_W-1:0]      dev_exp;

  // intake
  logic                         accept;
  logic                         start;
  logic                         band_ok;
  logic [CNT_W-1:0]             bir_eff;
  logic [REGION_W-1:0]          region_eff;
  logic                         region_end;
  logic signed [SUM_W-1:0]      sum_add;
  logic [CNT_W-1:0]             cnt_add;
  logic [SUM_W-1:0]             sum_neg;

  // divider
  logic [CNT_W:0]               trial;
  logic [CNT_W:0]               trial_diff;
  logic                         trial_ge;

  // deviation
  logic [BAND_W-1:0]            quo;
  logic signed [BAND_W-1:0]     avg_c;
  logic signed [DEV_W-1:0]      exp_c;
  logic signed [DEV_W:0]        dev_wide;
  logic signed [DEV_W-1:0]      dev_c;
  logic [DEV_W-1:0]             mag_c;

  // verdict
  logic                         load_out;
  logic [1:0]                   status_c;
  logic [REGION_W-1:0]          region_c;
  logic signed [DEV_W-1:0]      dev_out_c;
  logic                         excess_c;
  logic signed [BAND_W-1:0]     avg_out_c;
  logic signed [DEV_W-1:0]      tgt_out_c;

  assign band_stall = (state != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = band_valid && !band_stall;

  always_comb begin
    start      = first_band || ((bir == '0) && (region == '0));
    bir_eff    = start ? '0 : bir;
    region_eff = start ? '0 : region;
    region_end = (bir_eff == CNT_W'(BANDS_PER_REGION - 1));
    band_ok    = (band_energy > VALID_FLOOR);
    sum_add    = (start ? SUM_W'(0) : region_sum)
               + (band_ok ? {{CNT_W{band_energy[BAND_W-1]}}, band_energy} : SUM_W'(0));
    cnt_add    = (start ? CNT_W'(0) : valid_count) + CNT_W'(band_ok);
    sum_neg    = -sum_add;
  end

  always_comb begin
    trial      = {rem, dq[DVD_W-1]};
    trial_ge   = (trial >= {1'b0, div_cnt});
    trial_diff = trial - {1'b0, div_cnt};
  end

  always_comb begin
    quo   = dq[BAND_W-1:0];
    avg_c = div_neg ? -$signed(quo) : $signed(quo);
    if (div_cnt == '0) begin
      avg_c = '0;
    end
    exp_c    = {held_peak[BAND_W-1], held_peak} + {offset[region][BAND_W-1], offset[region]};
    dev_wide = {{2{avg_c[BAND_W-1]}}, avg_c} - {exp_c[DEV_W-1], exp_c};
    if (dev_wide[DEV_W] != dev_wide[DEV_W-1]) begin
      dev_c = dev_wide[DEV_W] ? DEV_MIN : DEV_MAX;
    end else begin
      dev_c = dev_wide[DEV_W-1:0];
    end
    if (div_cnt == '0) begin
      dev_c = '0;
    end
    mag_c = dev_c[DEV_W-1] ? -dev_c : dev_c;
  end

  always_comb begin
    status_c  = STATUS_ON;
    region_c  = NO_REGION;
    dev_out_c = '0;
    excess_c  = 1'b0;
    avg_out_c = '0;
    tgt_out_c = '0;
    if (held_peak < SIGNAL_FLOOR) begin
      status_c = STATUS_NO_SIGNAL;
    end else if (worst_index != NO_REGION) begin
      region_c  = worst_index;
      dev_out_c = worst_signed;
      avg_out_c = worst_avg;
      tgt_out_c = worst_target;
      if (worst_magnitude <= DEV_W'(tolerance)) begin
        status_c = STATUS_ON;
      end else begin
        status_c = (worst_magnitude <= DEV_W'(near_tolerance)) ? STATUS_NEAR : STATUS_OFF;
        excess_c = !worst_signed[DEV_W-1] && (worst_signed != '0);
      end
    end
  end

  assign load_out = (state == ST_EMIT) && (!verdict_valid || !verdict_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance      <= TOL_RESET;
      near_tolerance <= NEAR_RESET;
      for (int i = 0; i < NUM_OFFSETS; i++) begin
        offset[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TOL:   tolerance      <= cfg_data[TOL_W-1:0];
        REG_NEAR:  near_tolerance <= cfg_data[TOL_W-1:0];
        REG_OFF_A: offset[0]      <= cfg_data;
        REG_OFF_B: offset[1]      <= cfg_data;
        REG_OFF_C: offset[2]      <= cfg_data;
        REG_OFF_D: offset[3]      <= cfg_data;
        REG_OFF_E: offset[4]      <= cfg_data;
        REG_OFF_F: offset[5]      <= cfg_data;
        default:   tolerance      <= tolerance;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      bir             <= '0;
      region          <= '0;
      region_sum      <= '0;
      valid_count     <= '0;
      held_peak       <= '0;
      worst_magnitude <= '0;
      worst_index     <= NO_REGION;
      worst_signed    <= '0;
      worst_avg       <= '0;
      worst_target    <= '0;
      verdict_valid   <= 1'b0;
    end else begin
      if (load_out) begin
        verdict_valid <= 1'b1;
      end else if (verdict_valid && !verdict_stall) begin
        verdict_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (start) begin
              held_peak       <= peak_level;
              worst_magnitude <= '0;
              worst_index     <= NO_REGION;
              worst_signed    <= '0;
              worst_avg       <= '0;
              worst_target    <= '0;
            end
            region <= region_eff;
            if (region_end) begin
              bir         <= '0;
              region_sum  <= '0;
              valid_count <= '0;
              dq          <= sum_add[SUM_W-1] ? sum_neg[DVD_W-1:0] : sum_add[DVD_W-1:0];
              div_neg     <= sum_add[SUM_W-1];
              div_cnt     <= cnt_add;
              rem         <= '0;
              step        <= STEP_W'(DVD_W - 1);
              state       <= ST_DIV;
            end else begin
              bir         <= bir_eff + CNT_W'(1);
              region_sum  <= sum_add;
              valid_count <= cnt_add;
            end
          end
        end
        ST_DIV: begin
          rem <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
          dq  <= {dq[DVD_W-2:0], trial_ge};
          if (step == '0) begin
            state <= ST_DEV;
          end else begin
            step <= step - STEP_W'(1);
          end
        end
        ST_DEV: begin
          dev_sat <= dev_c;
          dev_mag <= mag_c;
          dev_avg <= avg_c;
          dev_exp <= exp_c;
          state   <= ST_UPD;
        end
        ST_UPD: begin
          if (dev_mag > worst_magnitude) begin
            worst_magnitude <= dev_mag;
            worst_index     <= region;
            worst_signed    <= dev_sat;
            worst_avg       <= dev_avg;
            worst_target    <= dev_exp;
          end
          if (region == REGION_W'(REGIONS - 1)) begin
            region <= '0;
            state  <= ST_EMIT;
          end else begin
            region <= region + REGION_W'(1);
            state  <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status          <= status_c;
      worst_region    <= region_c;
      worst_deviation <= dev_out_c;
      is_excess       <= excess_c;
      worst_energy    <= avg_out_c;
      worst_expected  <= tgt_out_c;
      peak_out        <= held_peak;
    end
  end

  a_worst_nonzero: assert property (@(posedge clk) disable iff (rst)
    (worst_index != NO_REGION) |-> (worst_magnitude != '0))
    else $error("worst region recorded with zero magnitude");

  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    (worst_magnitude <= DEV_W'(4096)))
    else $error("worst magnitude beyond saturated range");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |=> ((state == ST_DIV) || (state == ST_DEV)))
    else $error("divider left early");

  a_no_signal: assert property (@(posedge clk) disable iff (rst)
    (verdict_valid && (status == STATUS_NO_SIGNAL))
      |-> ((worst_region == NO_REGION) && (worst_deviation == '0) && !is_excess))
    else $error("no-signal verdict carries region data");

  a_excess: assert property (@(posedge clk) disable iff (rst)
    (verdict_valid && is_excess)
      |-> (!worst_deviation[DEV_W-1] && ((status == STATUS_NEAR) || (status == STATUS_OFF))))
    else $error("excess flag on wrong verdict");

endmodule
